// ----- rtl/kvm_pkg.sv -----
// ----------------------------------------------------------------------------
// kvm_pkg
// shared constants and types of the key/value map table
// ----------------------------------------------------------------------------
package kvm_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int ACT_W    = 2;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int OCNT_W   = 5;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    localparam int S_DATA_W = ((ACT_W + KEY_W + VAL_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((VAL_W + 1 + 1 + OCNT_W + 1 + KEY_W + 7) / 8) * 8;

    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ABSENT_VALUE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ABSENT_KEY   = 1'd1;

    localparam logic [CFG_W-1:0] ABSENT_RESET = 32'hFFFE_4DF9;

    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } slot_rd_t;

    typedef struct packed {
        logic                    ins;
        logic                    upd;
        logic                    clr;
        logic [IDX_W-1:0]        idx;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } slot_wr_t;

    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_res_t;

endpackage

// ----- rtl/kvm_slot_store.sv -----
// ----------------------------------------------------------------------------
// kvm_slot_store
// key, value and valid storage of the table slots, one read and one write port
// ----------------------------------------------------------------------------
module kvm_slot_store (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [kvm_pkg::IDX_W-1:0] rd_idx,
    output kvm_pkg::slot_rd_t         rd,
    input  kvm_pkg::slot_wr_t         wr
);
    import kvm_pkg::*;

    logic signed [KEY_W-1:0] key_mem [CAPACITY];
    logic signed [VAL_W-1:0] val_mem [CAPACITY];
    logic [CAPACITY-1:0]     valid_reg;
    slot_rd_t                rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.ins) begin
            valid_reg[wr.idx] <= 1'b1;
        end else if (wr.clr) begin
            valid_reg[wr.idx] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.ins) begin
            key_mem[wr.idx] <= wr.key;
        end
        if (wr.ins || wr.upd) begin
            val_mem[wr.idx] <= wr.value;
        end
    end

    // registered read, data follows the address in the next cycle
    always_ff @(posedge aclk) begin
        rd_reg.valid <= valid_reg[rd_idx];
        rd_reg.key   <= key_mem[rd_idx];
        rd_reg.value <= val_mem[rd_idx];
    end

    assign rd = rd_reg;

endmodule

// ----- rtl/kvm_cmp.sv -----
// ----------------------------------------------------------------------------
// kvm_cmp
// shared compare unit: key match and signed less-than against the running min
// ----------------------------------------------------------------------------
module kvm_cmp (
    input  logic signed [kvm_pkg::KEY_W-1:0] cand,
    input  logic signed [kvm_pkg::KEY_W-1:0] item_key,
    input  logic signed [kvm_pkg::KEY_W-1:0] min_key,
    output kvm_pkg::cmp_res_t                res
);
    import kvm_pkg::*;

    assign res.eq = (cand == item_key);
    assign res.lt = (cand < min_key);

endmodule

// ----- rtl/key_value_map_table_top.sv -----
// ----------------------------------------------------------------------------
// key_value_map_table_top
// bounded key/value table with add, search and remove, scanned slot by slot
// ----------------------------------------------------------------------------
// An item passes three states: ST_IDLE takes the beat, ST_SCAN reads the
// slots one by one while the single compare unit scans the table for the
// key, the lowest free slot and the smallest remaining key, and ST_FINISH
// folds in the item key and writes back. The result is held in an
// output register; s_tready rises again right after write back, and the next
// write back waits while an earlier result has not been taken.
module key_value_map_table_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [kvm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kvm_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // action, item_key, item_value
    input  logic [kvm_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // old_value, hit, table_full, entry_count, is_empty, smallest_key
    output logic [kvm_pkg::M_DATA_W-1:0]     m_tdata
);
    import kvm_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

    state_t                  state_reg;
    logic [ACT_W-1:0]        act_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic                    hit_reg;
    logic [IDX_W-1:0]        hit_idx_reg;
    logic signed [VAL_W-1:0] old_reg;
    logic                    any_reg;
    logic signed [KEY_W-1:0] min_reg;
    logic                    free_found_reg;
    logic [IDX_W-1:0]        free_idx_reg;
    logic [CNT_W-1:0]        count_reg;
    logic signed [VAL_W-1:0] absent_value_reg;
    logic signed [KEY_W-1:0] absent_key_reg;
    logic                    m_valid_reg;
    logic [M_DATA_W-1:0]     m_data_reg;

    slot_rd_t                rd;
    slot_wr_t                wr;
    cmp_res_t                res;
    logic signed [KEY_W-1:0] cand;
    logic [IDX_W-1:0]        rd_idx;

    logic                    finish_go;
    logic                    is_add;
    logic                    inserting;
    logic                    removing;
    logic                    full_flag;
    logic [CNT_W-1:0]        count_next;
    logic signed [KEY_W-1:0] min_next;
    logic signed [VAL_W-1:0] old_next;

    // address one slot ahead so the registered read lines up with idx_reg
    assign rd_idx = (state_reg == ST_SCAN) ? idx_reg + IDX_W'(1) : '0;

    kvm_slot_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_idx  (rd_idx),
        .rd      (rd),
        .wr      (wr)
    );

    assign cand = (state_reg == ST_FINISH) ? key_reg : rd.key;

    kvm_cmp u_cmp (
        .cand     (cand),
        .item_key (key_reg),
        .min_key  (min_reg),
        .res      (res)
    );

    always_comb begin
        is_add   = 1'b0;
        removing = 1'b0;
        case (act_reg)
            ACT_ADD:    is_add   = 1'b1;
            ACT_REMOVE: removing = hit_reg;
            default:    is_add   = 1'b0;
        endcase
        inserting  = is_add && !hit_reg && (count_reg < CNT_W'(CAPACITY)) && free_found_reg;
        full_flag  = is_add && !hit_reg && !inserting;
        count_next = count_reg;
        if (inserting) begin
            count_next = count_reg + CNT_W'(1);
        end else if (removing) begin
            count_next = count_reg - CNT_W'(1);
        end
        if (((hit_reg && !removing) || inserting) && (!any_reg || res.lt)) begin
            min_next = key_reg;
        end else if (any_reg) begin
            min_next = min_reg;
        end else begin
            min_next = absent_key_reg;
        end
        old_next  = hit_reg ? old_reg : absent_value_reg;
        finish_go = (state_reg == ST_FINISH) && (!m_valid_reg || m_tready);

        wr.ins   = finish_go && inserting;
        wr.upd   = finish_go && is_add && hit_reg;
        wr.clr   = finish_go && removing;
        wr.idx   = inserting ? free_idx_reg : hit_idx_reg;
        wr.key   = key_reg;
        wr.value = val_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            absent_value_reg <= ABSENT_RESET;
            absent_key_reg   <= ABSENT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ABSENT_VALUE: absent_value_reg <= cfg_wdata;
                REG_ABSENT_KEY:   absent_key_reg   <= cfg_wdata;
                default:          absent_value_reg <= absent_value_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            if (m_valid_reg && m_tready && !finish_go) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        act_reg        <= s_tdata[ACT_W-1:0];
                        key_reg        <= s_tdata[ACT_W +: KEY_W];
                        val_reg        <= s_tdata[ACT_W+KEY_W +: VAL_W];
                        idx_reg        <= '0;
                        hit_reg        <= 1'b0;
                        any_reg        <= 1'b0;
                        free_found_reg <= 1'b0;
                        state_reg      <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (rd.valid && res.eq) begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= idx_reg;
                        old_reg     <= rd.value;
                    end
                    if (!rd.valid && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= idx_reg;
                    end
                    if (rd.valid && !res.eq && (!any_reg || res.lt)) begin
                        any_reg <= 1'b1;
                        min_reg <= rd.key;
                    end
                    if (idx_reg == IDX_W'(CAPACITY - 1)) begin
                        state_reg <= ST_FINISH;
                    end else begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                ST_FINISH: begin
                    if (finish_go) begin
                        count_reg   <= count_next;
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= M_DATA_W'({min_next, (count_next == '0),
                                        OCNT_W'(count_next), full_flag, hit_reg, old_next});
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // count never beyond capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[VAL_W+2 +: OCNT_W] <= OCNT_W'(CAPACITY)))
        else $error("entry count beyond capacity");

    // empty flag agrees with count
    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[VAL_W+2+OCNT_W] == (m_tdata[VAL_W+2 +: OCNT_W] == '0)))
        else $error("empty flag disagrees with count");

    // refusal only on a miss with a full table
    a_full_refusal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[VAL_W+1]) |->
            (!m_tdata[VAL_W] && (m_tdata[VAL_W+2 +: OCNT_W] == OCNT_W'(CAPACITY))))
        else $error("table full flagged on hit or with room left");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready while an item is in work");

endmodule
